>>> sv/nmea_sentence_framer_macros.svh
// assertion macros shared by the framer's checker
// each macro expects clk and rst_n in the scope where it is used
`ifndef NMEA_SENTENCE_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define NSF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmea framer check failed");

// next-cycle implication, checked out of reset
`define NSF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmea framer check failed");

`endif

>>> sv/nsf_pkg.sv
// shared types, codes and helpers for the nmea sentence framer
// used by the top level and by its checker; depends on nothing else

package nsf_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 88;
    localparam int PADDR_W   = 4;

    localparam logic [7:0]  STAR_CHAR         = 8'h2A;
    localparam logic [7:0]  SYNC_RESET        = 8'd36;
    localparam logic [7:0]  MAX_DATA_RESET    = 8'd80;
    localparam logic [23:0] IDLE_LIMIT_RESET  = 24'd100000;

    // request kind on the input side
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kind on the output side
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_HEX  = 3'd4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_SYNC       = 2'd0;
    localparam logic [1:0] REG_MAX_DATA   = 2'd1;
    localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;

    // output data word, first field in the high bits, last field in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [2:0]  frame_status;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [7:0]  payload_length;
        logic [23:0] sentence_type;
        logic [15:0] talker_id;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
    } result_data_t;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        return r;
    endfunction

endpackage

>>> sv/nmea_sentence_framer.sv
// nmea 0183 sentence framer: sync hunt, id/type capture, data streaming, xor checksum
// depends on nsf_pkg
//
// channel   dir  beat
// s_*       in   one received byte (tuser 0) or one time tick (tuser 1)
// m_*       out  one data byte (tuser 0) or one end-of-frame report (tuser 1)
// apb       in   sync_char @0x0, max_data_bytes @0x4, idle_tick_limit @0x8
//
// one request per cycle; parser state and any result are registered at the edge
// that accepts the request, so a result shows on m_* in the next cycle
// s_tready drops only while the output register is full and m_tready is low
// reset returns to sync hunting with the register defaults

module nmea_sentence_framer
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nsf_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                            s_tuser,   // [0] operation

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [31:16] talker_id,
    // [55:32] sentence_type, [63:56] payload_length, [71:64] received_sum,
    // [79:72] computed_sum, [82:80] frame_status, [87:83] zero
    output logic [nsf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,   // [0] result_kind

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nsf_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import nsf_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_HEX  = 3'd4;

    logic [7:0]   sync_reg;
    logic [7:0]   max_data_reg;
    logic [23:0]  idle_limit_reg;

    logic [2:0]   phase_reg, phase_next;
    logic [1:0]   fpos_reg, fpos_next;
    logic [7:0]   xor_reg, xor_next;
    logic [15:0]  id_reg, id_next;
    logic [23:0]  type_reg, type_next;
    logic [3:0]   nib_reg, nib_next;
    logic         hexerr_reg, hexerr_next;
    logic [23:0]  idle_reg, idle_next;
    logic [7:0]   count_reg, count_next;

    logic         out_valid_reg;
    logic         out_kind_reg;
    result_data_t out_data_reg;

    logic         in_fire;
    logic         cfg_write;
    logic [7:0]   rx;
    logic [23:0]  idle_inc;
    logic [4:0]   hex;
    logic         hex_bad;
    logic [7:0]   rsum;
    logic         emit;
    logic         res_kind;
    result_data_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SYNC:       prdata = {24'd0, sync_reg};
            REG_MAX_DATA:   prdata = {24'd0, max_data_reg};
            REG_IDLE_LIMIT: prdata = {8'd0, idle_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg       <= SYNC_RESET;
            max_data_reg   <= MAX_DATA_RESET;
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SYNC:       sync_reg       <= pwdata[7:0];
                REG_MAX_DATA:   max_data_reg   <= pwdata[7:0];
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    assign s_tready = ~out_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign rx       = s_tdata[7:0];
    assign idle_inc = idle_reg + 24'd1;
    assign hex      = hex_decode(rx);
    assign hex_bad  = ~hex[4];
    assign rsum     = {nib_reg, hex[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        fpos_next   = fpos_reg;
        xor_next    = xor_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        nib_next    = nib_reg;
        hexerr_next = hexerr_reg;
        idle_next   = idle_reg;
        count_next  = count_reg;

        emit     = 1'b0;
        res_kind = KIND_REPORT;
        res      = '0;
        res.talker_id      = id_reg;
        res.sentence_type  = type_reg;
        res.payload_length = count_reg;
        res.computed_sum   = xor_reg;

        // clear_frame: shared by every path that returns to hunting
        if (in_fire)
        begin
            if (s_tuser == OP_TICK)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= idle_limit_reg)
                    begin
                        emit             = 1'b1;
                        res.frame_status = ST_TIMEOUT;
                        phase_next       = PH_HUNT;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx == sync_reg)
                            phase_next = PH_ID;
                    end
                    PH_ID:
                    begin
                        id_next  = {id_reg[7:0], rx};
                        xor_next = xor_reg ^ rx;
                        fpos_next = fpos_reg + 2'd1;
                        if (fpos_reg == 2'd1)
                        begin
                            fpos_next  = '0;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next = {type_reg[15:0], rx};
                        xor_next  = xor_reg ^ rx;
                        fpos_next = fpos_reg + 2'd1;
                        if (fpos_reg == 2'd2)
                        begin
                            fpos_next  = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (rx == STAR_CHAR)
                        begin
                            fpos_next  = '0;
                            phase_next = PH_HEX;
                        end
                        else if (count_reg >= max_data_reg)
                        begin
                            emit             = 1'b1;
                            res.frame_status = ST_OVERFLOW;
                            phase_next       = PH_HUNT;
                        end
                        else
                        begin
                            xor_next   = xor_reg ^ rx;
                            count_next = count_reg + 8'd1;
                            emit       = 1'b1;
                            res_kind   = KIND_DATA;
                            res.payload_byte   = rx;
                            res.payload_index  = count_reg;
                            res.payload_length = count_reg + 8'd1;
                            res.computed_sum   = xor_reg ^ rx;
                        end
                    end
                    PH_HEX:
                    begin
                        hexerr_next = hexerr_reg | hex_bad;
                        if (fpos_reg == 2'd0)
                        begin
                            nib_next  = hex[3:0];
                            fpos_next = 2'd1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            res.received_sum = rsum;
                            if (hexerr_reg | hex_bad)
                                res.frame_status = ST_BAD_HEX;
                            else if (rsum != xor_reg)
                                res.frame_status = ST_MISMATCH;
                            else
                                res.frame_status = ST_OK;
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end

            if (phase_next == PH_HUNT)
            begin
                fpos_next   = '0;
                xor_next    = '0;
                id_next     = '0;
                type_next   = '0;
                nib_next    = '0;
                hexerr_next = 1'b0;
                idle_next   = '0;
                count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            fpos_reg      <= '0;
            xor_reg       <= '0;
            id_reg        <= '0;
            type_reg      <= '0;
            nib_reg       <= '0;
            hexerr_reg    <= 1'b0;
            idle_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fpos_reg   <= fpos_next;
            xor_reg    <= xor_next;
            id_reg     <= id_next;
            type_reg   <= type_next;
            nib_reg    <= nib_next;
            hexerr_reg <= hexerr_next;
            idle_reg   <= idle_next;
            count_reg  <= count_next;
            if (s_tready)
                out_valid_reg <= in_fire & emit;
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> sv/nsf_checker.sv
// port-level checks for the nmea sentence framer, bound to the top level
// depends on nsf_pkg and nmea_sentence_framer_macros.svh

`include "nmea_sentence_framer_macros.svh"

module nsf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nsf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    import nsf_pkg::*;

    result_data_t d;
    assign d = m_tdata;

    // a stalled result must not move
    `NSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a data byte carries its own running count and no status
    `NSF_ASSERT_NOW(a_data_fields, m_tvalid && m_tuser == KIND_DATA, d.payload_length == d.payload_index + 8'd1 && d.frame_status == ST_OK && d.received_sum == 8'd0)

    // timeout and overflow reports never carry a decoded checksum
    `NSF_ASSERT_NOW(a_abort_sum, m_tvalid && m_tuser == KIND_REPORT && (d.frame_status == ST_TIMEOUT || d.frame_status == ST_OVERFLOW), d.received_sum == 8'd0 && d.payload_byte == 8'd0)

    // the input side is never blocked while the output register is empty
    `NSF_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready)

    // with no request accepted no new result may appear
    `NSF_ASSERT_NEXT(a_no_spurious, !(s_tvalid && s_tready) && !m_tvalid, !m_tvalid)

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (.*);
